// ===== design/sml_pkg.sv =====
// Shared types and constants for the sliding-window median size limit block.
// No dependencies; the interfaces and all modules but sml_ram import this package.
`default_nettype none
package sml_pkg;

	// Field widths fixed by the item and register formats.
	localparam int SIZE_W    = 32;
	localparam int WIN_LEN_W = 7;
	localparam int MULT_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = SIZE_W + MULT_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MULTIPLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT     = 2'd2;

	// Register reset values.
	localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST    = 7'd64;
	localparam logic [MULT_W-1:0]    SIZE_MULTIPLE_RST = 8'd2;
	localparam logic [SIZE_W-1:0]    MIN_LIMIT_RST     = 32'd1000000;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OLD,
		ST_WALK,
		ST_MED,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ===== design/sml_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on sml_pkg for field widths.
`default_nettype none
interface sml_in_if;
	import sml_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] new_size;
	logic              clear;
	modport source (output valid, output new_size, output clear, input ready);
	modport sink (input valid, input new_size, input clear, output ready);
endinterface

interface sml_out_if;
	import sml_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] size_limit;
	logic [SIZE_W-1:0] median_size;
	logic              window_full;
	modport source (output valid, output size_limit, output median_size,
		output window_full, input ready);
	modport sink (input valid, input size_limit, input median_size,
		input window_full, output ready);
endinterface

interface sml_cfg_if;
	import sml_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/sml_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module sml_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/sliding_median_size_limit.sv =====
// Sliding-window median size limit: arrival ring and sorted store in two RAMs.
// A size beat runs ST_OLD (ring read and write), ST_WALK (one pass over the n sizes
// held before it), ST_MED, ST_MUL and ST_FIN; a clear beat goes straight to ST_MED.
// A new beat is taken only in ST_IDLE, so the sequential walk of the sorted RAM sets
// the pace, and a stalled result holds off the next beat.
// Reset clears the fill count, ring pointer, sequencer and registers; RAM contents
// stay undefined until written and need no clearing pass. Depends on sml_pkg, sml_if, sml_ram.
`default_nettype none
module sliding_median_size_limit #(
	parameter int MAX_WINDOW = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sml_in_if.sink     item,
	sml_out_if.source  result,
	sml_cfg_if.sink    cfg
);
	import sml_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int LW = (CW > WIN_LEN_W) ? CW : WIN_LEN_W;

	// Configuration registers.
	logic [WIN_LEN_W-1:0] win_len_q;
	logic [MULT_W-1:0]    mult_q;
	logic [SIZE_W-1:0]    min_limit_q;

	// Sequencer and window control state.
	state_t        state_q, state_d;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] n_q;
	logic          full_q;
	logic          rm_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;

	// Item payload and walk datapath.
	logic [SIZE_W-1:0] carry_q;
	logic [SIZE_W-1:0] old_q;
	logic [SIZE_W-1:0] lo_q;
	logic [SIZE_W-1:0] hi_q;
	logic [SIZE_W-1:0] median_q;
	logic              win_full_q;
	logic [PROD_W-1:0] prod_q;

	// Result register.
	logic              out_valid_q;
	logic [SIZE_W-1:0] out_limit_q;
	logic [SIZE_W-1:0] out_median_q;
	logic              out_full_q;

	// RAM ports.
	logic              ring_we;
	logic [SIZE_W-1:0] ring_rdata;
	logic              srt_we;
	logic [AW-1:0]     srt_waddr;
	logic [SIZE_W-1:0] srt_wdata;
	logic [AW-1:0]     srt_raddr;
	logic [SIZE_W-1:0] srt_rdata;

	// Effective window length and normalized fill and pointer at acceptance.
	logic [LW-1:0] wl_ext;
	logic [CW-1:0] w_eff;
	logic          fill_over;
	logic [CW-1:0] fill_norm;
	logic [AW-1:0] ptr_norm;
	logic          accept;

	assign wl_ext    = LW'(win_len_q);
	assign w_eff     = (win_len_q == '0) ? CW'(1) :
		((wl_ext > LW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(win_len_q));
	assign fill_over = fill_q > w_eff;
	assign fill_norm = fill_over ? '0 : fill_q;
	assign ptr_norm  = (fill_over || (CW'(ptr_q) >= w_eff)) ? '0 : ptr_q;
	assign accept    = item.valid && item.ready;

	// Walk step: drop the first copy of the evicted size, merge the new one.
	logic              in_range;
	logic              skip;
	logic              take_carry;
	logic [SIZE_W-1:0] emit_val;
	logic [CW-1:0]     rd_next;
	logic [CW-1:0]     ptr_inc;
	logic [CW-1:0]     hw;

	assign in_range   = i_q < n_q;
	assign skip       = rm_q && (srt_rdata == old_q);
	assign take_carry = srt_rdata >= carry_q;
	assign emit_val   = take_carry ? carry_q : srt_rdata;
	assign rd_next    = i_q + CW'(1);
	assign ptr_inc    = CW'(ptr_q) + CW'(1);
	assign hw         = w_q >> 1;

	// Median and limit arithmetic.
	logic [SIZE_W:0]   mid_sum;
	logic [SIZE_W-1:0] sat_prod;
	logic [SIZE_W-1:0] limit;
	logic              out_free;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign sat_prod = (prod_q[PROD_W-1:SIZE_W] != '0) ? '1 : prod_q[SIZE_W-1:0];
	assign limit    = (sat_prod < min_limit_q) ? min_limit_q : sat_prod;
	assign out_free = !out_valid_q || result.ready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = item.clear ? ST_MED : ST_OLD;
				end
			end
			ST_OLD: state_d = ST_WALK;
			ST_WALK: begin
				if (!in_range) begin
					state_d = ST_MED;
				end
			end
			ST_MED: state_d = ST_MUL;
			ST_MUL: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs: handshakes and RAM ports.
	always_comb begin
		item.ready = 1'b0;
		ring_we    = 1'b0;
		srt_we     = 1'b0;
		srt_waddr  = j_q[AW-1:0];
		srt_wdata  = carry_q;
		srt_raddr  = '0;
		case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_OLD:  ring_we = 1'b1;
			ST_WALK: begin
				srt_raddr = rd_next[AW-1:0];
				if (in_range) begin
					srt_we    = !skip;
					srt_wdata = emit_val;
				end else begin
					srt_we    = 1'b1;
					srt_wdata = carry_q;
				end
			end
			default: begin
				item.ready = 1'b0;
			end
		endcase
	end

	assign cfg.ready          = 1'b1;
	assign result.valid       = out_valid_q;
	assign result.size_limit  = out_limit_q;
	assign result.median_size = out_median_q;
	assign result.window_full = out_full_q;

	// Control registers, configuration and window bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_len_q   <= WINDOW_LEN_RST;
			mult_q      <= SIZE_MULTIPLE_RST;
			min_limit_q <= MIN_LIMIT_RST;
			fill_q      <= '0;
			ptr_q       <= '0;
			w_q         <= CW'(1);
			n_q         <= '0;
			full_q      <= 1'b0;
			rm_q        <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Register writes; a window length write empties the window.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_WINDOW_LEN: begin
						win_len_q <= cfg.data[WIN_LEN_W-1:0];
						fill_q    <= '0;
						ptr_q     <= '0;
					end
					CFG_SIZE_MULTIPLE: mult_q <= cfg.data[MULT_W-1:0];
					CFG_MIN_LIMIT:     min_limit_q <= cfg.data;
					default: begin
						mult_q <= mult_q;
					end
				endcase
			end

			// Beat accepted: take the window length and normalize the state.
			if (accept) begin
				w_q    <= w_eff;
				n_q    <= fill_norm;
				full_q <= fill_norm == w_eff;
				rm_q   <= fill_norm == w_eff;
				i_q    <= '0;
				j_q    <= '0;
				if (item.clear) begin
					fill_q <= '0;
					ptr_q  <= '0;
				end else begin
					fill_q <= fill_norm;
					ptr_q  <= ptr_norm;
				end
			end

			// Ring slot written this cycle; advance the pointer.
			if (state_q == ST_OLD) begin
				ptr_q <= (ptr_inc >= w_q) ? '0 : ptr_inc[AW-1:0];
			end

			// Sorted walk counters.
			if (state_q == ST_WALK) begin
				if (in_range) begin
					i_q <= rd_next;
					if (skip) begin
						rm_q <= 1'b0;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end else if (!full_q) begin
					fill_q <= n_q + CW'(1);
				end
			end

			// Result register.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			carry_q <= item.new_size;
		end
		if (state_q == ST_OLD) begin
			old_q <= ring_rdata;
		end
		if (state_q == ST_WALK && in_range && !skip && take_carry) begin
			carry_q <= srt_rdata;
		end
		// Capture the middle entries as they are written back.
		if (srt_we && (j_q == hw)) begin
			hi_q <= srt_wdata;
		end
		if (srt_we && (j_q == hw - CW'(1))) begin
			lo_q <= srt_wdata;
		end
		if (state_q == ST_MED) begin
			win_full_q <= fill_q == w_q;
			if (fill_q != w_q) begin
				median_q <= '0;
			end else if (!w_q[0]) begin
				median_q <= mid_sum[SIZE_W:1];
			end else begin
				median_q <= hi_q;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(median_q) * PROD_W'(mult_q);
		end
		if (state_q == ST_FIN && out_free) begin
			out_limit_q  <= limit;
			out_median_q <= median_q;
			out_full_q   <= win_full_q;
		end
	end

	// Sizes in arrival order.
	sml_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ptr_q),
		.wdata (carry_q),
		.raddr (ptr_norm),
		.rdata (ring_rdata)
	);

	// Sizes in ascending order.
	sml_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (MAX_WINDOW)
	) u_sorted_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (srt_wdata),
		.raddr (srt_raddr),
		.rdata (srt_rdata)
	);

endmodule
`default_nettype wire

// ===== verif/median_limit_checker.sv =====
// Passive checker for the sliding-window median size limit block: it tracks register writes
// and size beats, predicts each result beat and compares it field by field.
// Depends on sml_pkg and the channel interfaces in sml_if.
`default_nettype none
module median_limit_checker #(
	parameter int MAX_WINDOW = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	sml_in_if        item,
	sml_out_if       result,
	sml_cfg_if       cfg,
	output int       fail_count,
	output int       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import sml_pkg::*;

	typedef struct packed {
		logic [SIZE_W-1:0] size_limit;
		logic [SIZE_W-1:0] median_size;
		logic              window_full;
	} limit_beat_t;

	// Register copies.
	logic [WIN_LEN_W-1:0] win_len_cfg;
	logic [MULT_W-1:0]    multiple_cfg;
	logic [SIZE_W-1:0]    min_limit_cfg;

	// Window contents in arrival order and in ascending order.
	logic [SIZE_W-1:0] held_sizes[MAX_WINDOW];
	logic [SIZE_W-1:0] ordered_sizes[MAX_WINDOW];
	int unsigned       held_count;
	int unsigned       next_slot;

	limit_beat_t expected_limits[$];
	limit_beat_t want;
	limit_beat_t fresh;

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Place a size in front of the first stored size that is not smaller.
	function automatic void insert_ordered(input int unsigned count, input logic [SIZE_W-1:0] sz);
		int unsigned pos;
		pos = 0;
		while (pos < count && ordered_sizes[pos] < sz) pos++;
		for (int unsigned i = count; i > pos; i--) ordered_sizes[i] = ordered_sizes[i-1];
		ordered_sizes[pos] = sz;
	endfunction

	// Advance the window by one beat and work out the limit that follows.
	task automatic predict_limit(input logic [SIZE_W-1:0] sz, input logic clr,
			output limit_beat_t got);
		int unsigned       w;
		int unsigned       kept;
		int unsigned       pos;
		logic [SIZE_W:0]   pair_sum;
		logic [PROD_W-1:0] product;
		w = (win_len_cfg == 0) ? 1 : win_len_cfg;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		if (clr) begin
			held_count = 0;
			next_slot = 0;
		end else begin
			if (held_count > w) begin
				held_count = 0;
				next_slot = 0;
			end
			if (next_slot >= w) next_slot = 0;
			if (held_count < w) begin
				insert_ordered(held_count, sz);
				held_count++;
			end else begin
				// Drop the first copy of the oldest size, then place the new one.
				kept = held_count;
				pos = 0;
				while (pos < kept && ordered_sizes[pos] != held_sizes[next_slot]) pos++;
				if (pos < kept) begin
					for (int unsigned i = pos; i + 1 < kept; i++) ordered_sizes[i] = ordered_sizes[i+1];
					kept--;
				end
				insert_ordered(kept, sz);
			end
			held_sizes[next_slot] = sz;
			next_slot = (next_slot + 1 >= w) ? 0 : next_slot + 1;
		end

		got.median_size = '0;
		got.window_full = 1'b0;
		if (held_count == w) begin
			got.window_full = 1'b1;
			if ((w % 2) == 0) begin
				// Even count: floor of the mean of the two middle sizes, no wrap.
				pair_sum = {1'b0, ordered_sizes[w/2]} + ordered_sizes[w/2-1];
				got.median_size = pair_sum[SIZE_W:1];
			end else begin
				got.median_size = ordered_sizes[w/2];
			end
		end

		// Saturate the product at 32 bits, then apply the floor.
		product = got.median_size * multiple_cfg;
		got.size_limit = (product > {SIZE_W{1'b1}}) ? '1 : product[SIZE_W-1:0];
		if (got.size_limit < min_limit_cfg) got.size_limit = min_limit_cfg;
	endtask

	// Register writes, then result beats, then newly accepted size beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_cfg = WINDOW_LEN_RST;
			multiple_cfg = SIZE_MULTIPLE_RST;
			min_limit_cfg = MIN_LIMIT_RST;
			held_count = 0;
			next_slot = 0;
			expected_limits.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_WINDOW_LEN: begin
						// A new length always empties the window.
						win_len_cfg = cfg.data[WIN_LEN_W-1:0];
						held_count = 0;
						next_slot = 0;
					end
					CFG_SIZE_MULTIPLE: begin
						multiple_cfg = cfg.data[MULT_W-1:0];
					end
					CFG_MIN_LIMIT: begin
						min_limit_cfg = cfg.data;
					end
					default: begin
					end
				endcase
			end

			if (result.valid && result.ready) begin
				if (expected_limits.size() == 0) begin
					report_mismatch("result beat with no size beat waiting for it");
				end else begin
					want = expected_limits.pop_front();
					if (result.size_limit !== want.size_limit) begin
						report_mismatch($sformatf("size_limit %h, expected %h",
							result.size_limit, want.size_limit));
					end
					if (result.median_size !== want.median_size) begin
						report_mismatch($sformatf("median_size %h, expected %h",
							result.median_size, want.median_size));
					end
					if (result.window_full !== want.window_full) begin
						report_mismatch($sformatf("window_full %b, expected %b",
							result.window_full, want.window_full));
					end
				end
			end

			if (item.valid && item.ready) begin
				predict_limit(item.new_size, item.clear, fresh);
				expected_limits = {expected_limits, fresh};
			end

			outstanding <= expected_limits.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Top of the testbench for the sliding-window median size limit block: clock, reset,
// register programming, size beats and receiver back-pressure, plus the final verdict.
// Depends on sml_pkg, sml_if, the block itself and median_limit_checker.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sml_pkg::*;

	localparam int MAX_WINDOW     = 64;
	localparam int CLK_PERIOD     = 20;
	localparam int TIMEOUT_CYCLES = 400_000;
	localparam int HOLD_CYCLES    = 300;
	localparam int ITEMS_PER_MODE = 120;

	// Index with no register behind it; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [SIZE_W:0]      CLEAR_BEAT = {1'b1, {SIZE_W{1'b0}}};

	logic clk = 1'b0;
	logic arst_n;

	int fail_count;
	int outstanding;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	logic [SIZE_W:0] directed_beats[$];

	sml_in_if  item_ch();
	sml_out_if result_ch();
	sml_cfg_if cfg_ch();

	sliding_median_size_limit #(
		.MAX_WINDOW(MAX_WINDOW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	median_limit_checker #(
		.MAX_WINDOW(MAX_WINDOW)
	) limit_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] word);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= word;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// Program all three registers; the upper data bits are noise the block must drop.
	task automatic program_regs(input logic [WIN_LEN_W-1:0] wl, input logic [MULT_W-1:0] mult,
			input logic [SIZE_W-1:0] minl);
		logic [SIZE_W-1:0] word;
		if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom);
		word = $urandom;
		word[WIN_LEN_W-1:0] = wl;
		write_reg(CFG_WINDOW_LEN, word);
		word = $urandom;
		word[MULT_W-1:0] = mult;
		write_reg(CFG_SIZE_MULTIPLE, word);
		write_reg(CFG_MIN_LIMIT, minl);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_item(input logic [SIZE_W-1:0] sz, input logic clr);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.new_size <= sz;
		item_ch.clear    <= clr;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// Sample outstanding only after the checker has counted the last accepted beat.
	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic run_directed(input logic [WIN_LEN_W-1:0] wl, input logic [MULT_W-1:0] mult,
			input logic [SIZE_W-1:0] minl);
		program_regs(wl, mult, minl);
		foreach (directed_beats[i]) send_item(directed_beats[i][SIZE_W-1:0], directed_beats[i][SIZE_W]);
		item_ch.valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		int                   sent;
		int                   phase_items;
		int                   eff_len;
		bit                   first_phase;
		logic [WIN_LEN_W-1:0] wl;
		logic [MULT_W-1:0]    mult;
		logic [SIZE_W-1:0]    minl;
		logic [SIZE_W-1:0]    sz;
		logic                 clr;

		arst_n           <= 1'b0;
		item_ch.valid    <= 1'b0;
		item_ch.new_size <= '0;
		item_ch.clear    <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= CFG_WINDOW_LEN;
		cfg_ch.data      <= '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Even window: clear on an empty window, all-ones pair without wrap, saturation.
		directed_beats = '{CLEAR_BEAT | 33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF,
			33'h0, 33'h0_FFFF_FFFF, 33'h0, 33'h1};
		run_directed(7'd4, 8'd255, 32'd0);
		// Zero length acts as one; zero multiple leaves only the floor.
		directed_beats = '{33'h5, 33'h0_1234_5678, CLEAR_BEAT};
		run_directed(7'd0, 8'd0, 32'hFFFF_FFFF);
		// Length past the maximum is cut to the maximum; the window stays unfilled.
		directed_beats = '{33'h0_8000_0000, 33'h7, 33'h0_FFFF_FFFE};
		run_directed(7'd127, 8'd1, 32'd0);
		// Single-entry window, clear in between.
		directed_beats = '{33'h0_8000_0000, 33'h0_7FFF_FFFF, CLEAR_BEAT, 33'h0};
		run_directed(7'd1, 8'd1, 32'd0);
		// Odd window with duplicate sizes leaving one at a time.
		directed_beats = '{33'd10, 33'd3, 33'd3, 33'd0, 33'd20, 33'd3};
		run_directed(7'd3, 8'd2, 32'd7);

		// Random part in three idling modes.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			first_phase = 1'b1;
			while (sent < ITEMS_PER_MODE) begin
				case ($urandom_range(9))
					0: wl = 7'd0;
					1: wl = WIN_LEN_W'($urandom_range(MAX_WINDOW + 1, 127));
					2: wl = WIN_LEN_W'(MAX_WINDOW);
					default: wl = WIN_LEN_W'($urandom_range(1, 12));
				endcase
				case ($urandom_range(7))
					0: mult = 8'd0;
					1: mult = 8'd1;
					2: mult = 8'd255;
					default: mult = MULT_W'($urandom_range(1, 255));
				endcase
				case ($urandom_range(7))
					0: minl = '0;
					1: minl = '1;
					2: minl = $urandom;
					default: minl = $urandom_range(0, 5000);
				endcase
				program_regs(wl, mult, minl);

				eff_len = (wl == 0) ? 1 : ((wl > MAX_WINDOW) ? MAX_WINDOW : wl);
				phase_items = (eff_len == MAX_WINDOW) ? eff_len + $urandom_range(8, 24)
					: 2 * eff_len + $urandom_range(2, 16);

				// Long receiver hold-off while sizes keep coming, so the input stalls.
				if (first_phase) hold_left = HOLD_CYCLES;
				first_phase = 1'b0;

				repeat (phase_items) begin
					clr = ($urandom_range(39) == 0);
					case ($urandom_range(9))
						0: sz = '1;
						1: sz = '0;
						2, 3: sz = $urandom_range(0, 15);
						4: sz = '1 - $urandom_range(0, 15);
						default: sz = $urandom;
					endcase
					send_item(sz, clr);
					sent++;
				end
				item_ch.valid <= 1'b0;
				// Sender pauses here until every result of the phase is back.
				wait_drained();
			end
		end

		wait_drained();
		repeat (MAX_WINDOW + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
